// ===== sv/vn2c_pkg.sv =====
// vn2c_pkg: types, constants and the cosine table shared by the value noise blocks
// no dependencies

package vn2c_pkg;

  // lattice hash constants
  localparam logic [31:0] HASH_MUL_A = 32'd15731;
  localparam logic [31:0] HASH_ADD_B = 32'd789221;
  localparam logic [31:0] HASH_ADD_C = 32'd1376312589;
  localparam logic [31:0] ROW_MUL    = 32'd57;

  // blend weight scale
  localparam logic [17:0] WEIGHT_ONE = 18'd65536;
  localparam logic [9:0]  IDX_HALF   = 10'd512;
  localparam int          QUAD_DEPTH = 512;

  // load enables of the four hash pipeline stages
  typedef struct packed {
    logic m;
    logic mm;
    logic t;
    logic b;
  } vn2c_hash_ld_t;

  typedef logic [16:0] cos_tab_t [QUAD_DEPTH];

  localparam logic [63:0] Q60_ONE = 64'h1000_0000_0000_0000;
  localparam logic [63:0] PI_Q60  = 64'h3243_F6A8_885A_308D;

  // (a * b) >> 60 on unsigned q60 values
  function automatic logic [63:0] mul_q60(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] p;
    p = a * b;
    return p[123:60];
  endfunction

  // trunc(65536*cos(pi*i/1024)) for the first quadrant, by taylor series
  function automatic logic [16:0] cos_quadrant(input int unsigned i);
    logic [63:0] t;
    logic [63:0] t2;
    logic [63:0] term;
    logic [63:0] pos;
    logic [63:0] neg;
    logic [63:0] diff;
    logic [63:0] ii;
    ii   = 64'(i);
    t    = (PI_Q60 >> 10) * ii + (((PI_Q60 & 64'd1023) * ii) >> 10);
    t2   = mul_q60(t, t);
    term = Q60_ONE;
    pos  = Q60_ONE;
    neg  = 64'd0;
    for (int k = 1; k <= 30; k++) begin
      term = mul_q60(term, t2) / 64'((2 * k - 1) * (2 * k));
      if (k % 2 == 1) neg = neg + term;
      else pos = pos + term;
    end
    if (neg >= pos) return 17'd0;
    diff = (pos - neg) >> 44;
    return diff[16:0];
  endfunction

  function automatic cos_tab_t build_cos_tab();
    cos_tab_t tab;
    for (int unsigned i = 0; i < QUAD_DEPTH; i++) tab[i] = cos_quadrant(i);
    return tab;
  endfunction

  localparam cos_tab_t COS_TAB = build_cos_tab();

endpackage

// ===== sv/value_noise_2d_cosine.sv =====
// value_noise_2d_cosine: top level of the smoothed 2d value noise pipeline
// depends on vn2c_pkg, vn2c_hash, vn2c_cos, vn2c_blend

// Smoothed 2D value noise with cosine blending. One request is accepted in
// every cycle unless in_stall is high. Each request gives one noise byte,
// shown with out_valid once it reaches the last stage. The nine-stage pipeline
// is capture, split, hash in four stages, smoothing and two blend stages. A
// bubble in the pipeline is filled even while out_stall holds a finished
// result, so the input stalls only when every stage is full.

module value_noise_2d_cosine (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [30:0] in_x_coord,
  input  logic [30:0] in_y_coord,
  input  logic [4:0]  in_freq_log2,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_noise_value
);
  import vn2c_pkg::*;

  localparam int NST = 9;

  logic [NST:1] v_r;
  logic [NST:1] ld;

  // stage 1: captured request
  logic [30:0] x_r, y_r;
  logic [4:0]  sh_r;

  // stage 2: cell and table index
  logic [31:0] cx_r, cy_r, cx_nxt, cy_nxt;
  logic [9:0]  ix_r, iy_r, ix_nxt, iy_nxt;
  logic [31:0] fmask;
  logic [41:0] fxs, fys;

  // weights and bytes
  logic [16:0] kx3, ky3;
  logic [16:0] kx4_r, kx5_r, kx6_r, kx7_r;
  logic [16:0] ky4_r, ky5_r, ky6_r, ky7_r, ky8_r;
  logic [7:0]  lb [16];
  logic [31:0] px [4];
  logic [31:0] py [4];
  logic [7:0]  s_r [4];
  logic [7:0]  s_nxt [4];
  logic [7:0]  top_v, bot_v, res_v;
  vn2c_hash_ld_t hld;

  // load chain, a stage takes data when empty or when it hands on
  always_comb begin
    ld[NST] = !v_r[NST] || !out_stall;
    for (int i = NST - 1; i >= 1; i--) ld[i] = !v_r[i] || ld[i + 1];
  end

  assign in_stall = !ld[1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (ld[1]) v_r[1] <= in_valid;
      for (int i = 2; i <= NST; i++) begin
        if (ld[i]) v_r[i] <= v_r[i - 1];
      end
    end
  end

  // split into cell and fraction
  always_comb begin
    fmask  = ~(32'hFFFF_FFFF << sh_r);
    cx_nxt = {1'b0, x_r} >> sh_r;
    cy_nxt = {1'b0, y_r} >> sh_r;
    fxs    = {({1'b0, x_r} & fmask), 10'd0} >> sh_r;
    fys    = {({1'b0, y_r} & fmask), 10'd0} >> sh_r;
    ix_nxt = fxs[9:0];
    iy_nxt = fys[9:0];
  end

  always_ff @(posedge clk) begin
    if (ld[1]) begin
      x_r  <= in_x_coord;
      y_r  <= in_y_coord;
      sh_r <= in_freq_log2;
    end
    if (ld[2]) begin
      cx_r <= cx_nxt;
      cy_r <= cy_nxt;
      ix_r <= ix_nxt;
      iy_r <= iy_nxt;
    end
  end

  // neighbour cells, from one left to two right, wrapping
  always_comb begin
    for (int d = 0; d < 4; d++) begin
      px[d] = cx_r + 32'(d) - 32'd1;
      py[d] = cy_r + 32'(d) - 32'd1;
    end
  end

  assign hld = '{m: ld[3], mm: ld[4], t: ld[5], b: ld[6]};

  for (genvar g = 0; g < 16; g++) begin : g_hash
    vn2c_hash u_hash (
      .clk      (clk),
      .ld       (hld),
      .cell_x   (px[g % 4]),
      .cell_y   (py[g / 4]),
      .lat_byte (lb[g])
    );
  end

  vn2c_cos u_cos_x (.clk(clk), .ld(ld[3]), .idx(ix_r), .weight(kx3));
  vn2c_cos u_cos_y (.clk(clk), .ld(ld[3]), .idx(iy_r), .weight(ky3));

  // carry the weights alongside the hash
  always_ff @(posedge clk) begin
    if (ld[4]) begin
      kx4_r <= kx3;
      ky4_r <= ky3;
    end
    if (ld[5]) begin
      kx5_r <= kx4_r;
      ky5_r <= ky4_r;
    end
    if (ld[6]) begin
      kx6_r <= kx5_r;
      ky6_r <= ky5_r;
    end
    if (ld[7]) begin
      kx7_r <= kx6_r;
      ky7_r <= ky6_r;
    end
    if (ld[8]) ky8_r <= ky7_r;
  end

  // 3x3 smoothing at the four cell corners
  always_comb begin
    logic [9:0] dg, eg;
    int ox, oy;
    for (int c = 0; c < 4; c++) begin
      ox = c % 2;
      oy = c / 2;
      dg = 10'(lb[oy * 4 + ox]) + 10'(lb[oy * 4 + ox + 2])
         + 10'(lb[(oy + 2) * 4 + ox]) + 10'(lb[(oy + 2) * 4 + ox + 2]);
      eg = 10'(lb[(oy + 1) * 4 + ox]) + 10'(lb[(oy + 1) * 4 + ox + 2])
         + 10'(lb[oy * 4 + ox + 1]) + 10'(lb[(oy + 2) * 4 + ox + 1]);
      s_nxt[c] = 8'(dg >> 4) + 8'(eg >> 3) + (lb[(oy + 1) * 4 + ox + 1] >> 2);
    end
  end

  always_ff @(posedge clk) begin
    if (ld[7]) begin
      for (int c = 0; c < 4; c++) s_r[c] <= s_nxt[c];
    end
  end

  // blend along x, then along y
  vn2c_blend u_top (.clk(clk), .ld(ld[8]), .a(s_r[0]), .b(s_r[1]), .weight(kx7_r),
                    .res(top_v));
  vn2c_blend u_bot (.clk(clk), .ld(ld[8]), .a(s_r[2]), .b(s_r[3]), .weight(kx7_r),
                    .res(bot_v));
  vn2c_blend u_fin (.clk(clk), .ld(ld[9]), .a(top_v), .b(bot_v), .weight(ky8_r),
                    .res(res_v));

  assign out_valid       = v_r[NST];
  assign out_noise_value = res_v;

endmodule

// ===== sv/vn2c_hash.sv =====
// vn2c_hash: four-stage pipelined lattice hash, one byte per lattice point
// depends on vn2c_pkg

module vn2c_hash (
  input  logic                   clk,
  input  vn2c_pkg::vn2c_hash_ld_t ld,
  input  logic [31:0]            cell_x,
  input  logic [31:0]            cell_y,
  output logic [7:0]             lat_byte
);
  import vn2c_pkg::*;

  logic [31:0] n;
  logic [31:0] m_r, m_nxt;
  logic [31:0] m4_r, mm_r, mm_nxt;
  logic [31:0] m5_r, t_r, t_nxt;
  logic [31:0] h;
  logic [7:0]  b_r;

  // point number and first mix
  always_comb begin
    n     = cell_y * ROW_MUL + cell_x;
    m_nxt = (n << 13) ^ n;
  end

  // square, polynomial and final product
  always_comb begin
    mm_nxt = m_r * m_r;
    t_nxt  = mm_r * HASH_MUL_A + HASH_ADD_B;
    h      = m5_r * t_r + HASH_ADD_C;
  end

  always_ff @(posedge clk) begin
    if (ld.m) m_r <= m_nxt;
    if (ld.mm) begin
      mm_r <= mm_nxt;
      m4_r <= m_r;
    end
    if (ld.t) begin
      t_r  <= t_nxt;
      m5_r <= m4_r;
    end
    if (ld.b) b_r <= h[26:19];
  end

  assign lat_byte = b_r;

endmodule

// ===== sv/vn2c_cos.sv =====
// vn2c_cos: cosine table lookup, gives the registered blend weight
// depends on vn2c_pkg

module vn2c_cos (
  input  logic        clk,
  input  logic        ld,
  input  logic [9:0]  idx,
  output logic [16:0] weight
);
  import vn2c_pkg::*;

  logic [8:0]  q;
  logic [9:0]  mirror;
  logic [17:0] c;
  logic [17:0] num;
  logic [16:0] weight_r, weight_nxt;

  // fold the half period onto the first quadrant
  always_comb begin
    mirror = 10'd0 - idx;
    q      = (idx > IDX_HALF) ? mirror[8:0] : idx[8:0];
    c      = {1'b0, COS_TAB[q]};
    if (idx == IDX_HALF) num = WEIGHT_ONE;
    else if (idx > IDX_HALF) num = WEIGHT_ONE + c;
    else num = WEIGHT_ONE - c;
    weight_nxt = num[17:1];
  end

  always_ff @(posedge clk) begin
    if (ld) weight_r <= weight_nxt;
  end

  assign weight = weight_r;

endmodule

// ===== sv/vn2c_blend.sv =====
// vn2c_blend: one registered cosine blend of two bytes by a weight
// depends on vn2c_pkg

module vn2c_blend (
  input  logic        clk,
  input  logic        ld,
  input  logic [7:0]  a,
  input  logic [7:0]  b,
  input  logic [16:0] weight,
  output logic [7:0]  res
);
  import vn2c_pkg::*;

  logic [17:0] inv;
  logic [25:0] pb, pa;
  logic [10:0] sum;
  logic [7:0]  res_r;

  // weighted sum, each term truncated
  always_comb begin
    inv = WEIGHT_ONE - {1'b0, weight};
    pb  = 26'({9'd0, weight} * {18'd0, b});
    pa  = 26'({8'd0, inv} * {18'd0, a});
    sum = {1'b0, pb[25:16]} + {1'b0, pa[25:16]};
  end

  always_ff @(posedge clk) begin
    if (ld) res_r <= sum[7:0];
  end

  assign res = res_r;

endmodule

// ===== verif/tb_value_noise_2d_cosine.sv =====
// tb_value_noise_2d_cosine: stimulus, prediction and checking for value_noise_2d_cosine
// depends on value_noise_2d_cosine and the vn2c_pkg package it compiles with
`timescale 1ns / 100ps

module tb_value_noise_2d_cosine;

  localparam int LIMIT_CYCLES = 400000;
  localparam int RANDOM_REQS  = 1900;
  localparam int DRAIN_CYCLES = 20;
  localparam logic [30:0] COORD_MAX = 31'h7fff_ffff;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [30:0] in_x_coord = '0;
  logic [30:0] in_y_coord = '0;
  logic [4:0]  in_freq_log2 = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  out_noise_value;

  typedef struct packed {
    logic [30:0] x;
    logic [30:0] y;
    logic [4:0]  f;
  } noise_req_t;

  logic [7:0]  noise_q [$];
  logic [16:0] cos_quarter [512];
  int          mismatches = 0;
  int          cycles = 0;

  value_noise_2d_cosine dut (.*);

  always #5 clk = ~clk;

  // fixed point multiply, result scaled back by 2^60
  function automatic logic [63:0] q60_product(logic [63:0] a, logic [63:0] b);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    return p[123:60];
  endfunction

  // first quadrant cosine in 1/65536 units, truncated, by taylor series in q60
  function automatic logic [16:0] quarter_cosine(int unsigned i);
    logic [63:0] pi_q;
    logic [63:0] ang;
    logic [63:0] ang_sq;
    logic [63:0] term;
    logic [63:0] plus;
    logic [63:0] minus;
    logic [63:0] res;
    pi_q   = 64'h3243_F6A8_885A_308D;
    ang    = (pi_q >> 10) * 64'(i) + (((pi_q & 64'd1023) * 64'(i)) >> 10);
    ang_sq = q60_product(ang, ang);
    term   = 64'h1000_0000_0000_0000;
    plus   = term;
    minus  = '0;
    for (int k = 1; k <= 30; k++) begin
      term = q60_product(term, ang_sq) / 64'((2 * k - 1) * (2 * k));
      if (k[0]) minus += term;
      else plus += term;
    end
    if (minus >= plus) return '0;
    res = (plus - minus) >> 44;
    return res[16:0];
  endfunction

  // signed cosine table entry for a half-turn index
  function automatic int signed cos_entry(logic [31:0] idx);
    int unsigned i;
    i = idx & 32'd2047;
    if (i > 1024) i = 2048 - i;
    if (i == 512) return 0;
    if (i > 512) return -int'(cos_quarter[1024 - i]);
    return int'(cos_quarter[i]);
  endfunction

  function automatic logic [31:0] lattice_hash(logic [31:0] cx, logic [31:0] cy);
    logic [31:0] n;
    logic [31:0] m;
    logic [31:0] h;
    n = cy * 32'd57 + cx;
    m = (n << 13) ^ n;
    h = (m * (m * m * 32'd15731 + 32'd789221) + 32'd1376312589) & 32'h7fff_ffff;
    return (h >> 19) & 32'hff;
  endfunction

  // 3x3 weighted smoothing around a lattice point
  function automatic logic [31:0] smooth_at(logic [31:0] cx, logic [31:0] cy);
    logic [31:0] diag;
    logic [31:0] side;
    diag = lattice_hash(cx - 1, cy - 1) + lattice_hash(cx + 1, cy - 1)
         + lattice_hash(cx - 1, cy + 1) + lattice_hash(cx + 1, cy + 1);
    side = lattice_hash(cx - 1, cy) + lattice_hash(cx + 1, cy)
         + lattice_hash(cx, cy - 1) + lattice_hash(cx, cy + 1);
    return (diag >> 4) + (side >> 3) + (lattice_hash(cx, cy) >> 2);
  endfunction

  function automatic logic [31:0] cos_mix(logic [31:0] a, logic [31:0] b,
                                          logic [31:0] frac, logic [4:0] sh);
    logic [63:0] idx;
    longint      c;
    logic [63:0] k;
    idx = ({32'd0, frac} << 10) >> sh;
    c   = cos_entry(idx[31:0]);
    k   = 64'(65536 - c) >> 1;
    return 32'(((k * b) >> 16) + (((64'd65536 - k) * a) >> 16));
  endfunction

  function automatic logic [7:0] noise_of(noise_req_t r);
    logic [31:0] mask;
    logic [31:0] cx, cy, fx, fy;
    logic [31:0] top, bot, res;
    mask = 32'((64'd1 << r.f) - 1);
    cx = {1'b0, r.x} >> r.f;
    cy = {1'b0, r.y} >> r.f;
    fx = {1'b0, r.x} & mask;
    fy = {1'b0, r.y} & mask;
    top = cos_mix(smooth_at(cx, cy), smooth_at(cx + 1, cy), fx, r.f);
    bot = cos_mix(smooth_at(cx, cy + 1), smooth_at(cx + 1, cy + 1), fx, r.f);
    res = cos_mix(top, bot, fy, r.f);
    return res[7:0];
  endfunction

  // directed requests: extremes, wrapping cells, a range of period sizes including 0 and 31
  noise_req_t directed [] = '{
    '{31'd0, 31'd0, 5'd0},           '{COORD_MAX, COORD_MAX, 5'd0},
    '{COORD_MAX, 31'd0, 5'd0},       '{31'd0, COORD_MAX, 5'd0},
    '{31'd0, 31'd0, 5'd31},          '{COORD_MAX, COORD_MAX, 5'd31},
    '{COORD_MAX, COORD_MAX, 5'd16},  '{31'h0000_ffff, 31'h0000_8000, 5'd16},
    '{31'd1, 31'd1, 5'd1},           '{31'd3, 31'd2, 5'd2},
    '{31'h2aaa_aaaa, 31'h5555_5555, 5'd5},
    '{31'h5555_5555, 31'h2aaa_aaaa, 5'd10},
    '{COORD_MAX, 31'h0001_ffff, 5'd17},
    '{31'h4000_0000, 31'h3fff_ffff, 5'd30},
    '{31'h1234_5678, 31'h0765_4321, 5'd24},
    '{31'd1023, 31'd512, 5'd10},     '{31'd7, 31'd9, 5'd4},
    '{COORD_MAX - 1, COORD_MAX - 1, 5'd0}
  };

  // one request, held until the block takes it
  task automatic send(noise_req_t r);
    in_valid     <= 1'b1;
    in_x_coord   <= r.x;
    in_y_coord   <= r.y;
    in_freq_log2 <= r.f;
    do @(posedge clk); while (in_stall);
    noise_q.push_back(noise_of(r));
  endtask

  function automatic noise_req_t random_req();
    noise_req_t r;
    r.x = 31'($urandom);
    r.y = 31'($urandom);
    case ($urandom_range(0, 9))
      0: r.f = 5'($urandom_range(17, 31));
      1: begin
        r.x = 31'($urandom_range(0, 300));
        r.y = 31'($urandom_range(0, 300));
        r.f = 5'($urandom_range(0, 4));
      end
      default: r.f = 5'($urandom_range(0, 16));
    endcase
    return r;
  endfunction

  // sender: bursts of requests with idle gaps between some of them
  initial begin
    int burst;
    int sent;
    for (int i = 0; i < 512; i++) cos_quarter[i] = quarter_cosine(i);
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (directed[i]) send(directed[i]);
    sent = 0;
    while (sent < RANDOM_REQS) begin
      burst = $urandom_range(1, 40);
      for (int j = 0; j < burst && sent < RANDOM_REQS; j++) begin
        send(random_req());
        sent++;
      end
      if ($urandom_range(0, 3) != 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
    end
    in_valid <= 1'b0;
    while (noise_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) $display("tb_value_noise_2d_cosine: done, clean");
    else $display("tb_value_noise_2d_cosine: done, errors");
    $finish;
  end

  // result check and receiver stall pattern, whose mode is taken from bits 9:8 of the cycle count
  always @(posedge clk) begin
    logic [7:0] want;
    cycles <= cycles + 1;
    if (rst_n && out_valid && !out_stall) begin
      if (noise_q.size() == 0) begin
        mismatches <= mismatches + 1;
        if (mismatches < 10) $display("unexpected result %0d", out_noise_value);
      end else begin
        want = noise_q.pop_front();
        if (want !== out_noise_value) begin
          mismatches <= mismatches + 1;
          if (mismatches < 10)
            $display("noise mismatch: expected %0d, got %0d", want, out_noise_value);
        end
      end
    end
    case (cycles[9:8])
      2'd0: out_stall <= 1'b0;
      2'd1: out_stall <= ($urandom_range(0, 9) < 3);
      2'd2: out_stall <= (cycles[2:0] == 3'd5);
      default: out_stall <= ($urandom_range(0, 1) == 1);
    endcase
  end

  // hang guard
  always @(posedge clk) begin
    if (cycles > LIMIT_CYCLES) begin
      $display("tb_value_noise_2d_cosine: done, errors");
      $finish;
    end
  end

endmodule
